[rtl/core/cfdc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the chunk frustum/distance cull block.
// No dependencies.
package cfdc_pkg;

    localparam int COORD_W       = 16;
    localparam int DIST_W        = 8;
    localparam int ENTRY_W       = 32;
    localparam int COEF_W        = ENTRY_W + 1;
    localparam int INDEX_W       = 4;
    localparam int MAT_DEPTH     = 16;
    localparam int NUM_PLANES    = 6;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam int CHUNK_SIZE_DEF   = 16;
    localparam int CHUNK_HEIGHT_DEF = 256;

    localparam logic [DIST_W-1:0] RENDER_DIST_RST = 8'd8;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_e;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_CAMERA_X    = 2'd0,
        CFG_CAMERA_Z    = 2'd1,
        CFG_RENDER_DIST = 2'd2
    } cfg_reg_e;

    typedef struct packed
    {
        logic                       operation;
        logic [INDEX_W-1:0]         entry_index;
        logic signed [ENTRY_W-1:0]  entry_value;
        logic signed [COORD_W-1:0]  chunk_x;
        logic signed [COORD_W-1:0]  chunk_z;
        logic                       has_geometry;
    } chunk_item_t;

    typedef struct packed
    {
        logic draw;
        logic distance_culled;
        logic frustum_culled;
    } verdict_t;

    // Capture enables for the lane stages
    typedef struct packed
    {
        logic s3;
        logic s4;
        logic s5;
    } adv_t;

endpackage

[rtl/core/cfdc_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels for chunk items and verdicts.
// Depends on cfdc_pkg.
interface cfdc_chunk_if;
    logic                   valid;
    logic                   ready;
    cfdc_pkg::chunk_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cfdc_verdict_if;
    logic                valid;
    logic                ready;
    cfdc_pkg::verdict_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/cfdc_plane_lane.sv]
`timescale 1ns / 1ps
// One clip-plane test: positive-vertex products, partial sums, sign.
// Depends on cfdc_pkg. Three register stages, no reset (payload only).
module cfdc_plane_lane #(
    parameter int CORW         = 22,
    parameter int CHUNK_HEIGHT = cfdc_pkg::CHUNK_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  cfdc_pkg::adv_t                       adv,
    input  logic signed [cfdc_pkg::COEF_W-1:0]   coef_a,
    input  logic signed [cfdc_pkg::COEF_W-1:0]   coef_b,
    input  logic signed [cfdc_pkg::COEF_W-1:0]   coef_c,
    input  logic signed [cfdc_pkg::COEF_W-1:0]   coef_d,
    input  logic signed [CORW-1:0]               min_x,
    input  logic signed [CORW-1:0]               max_x,
    input  logic signed [CORW-1:0]               min_z,
    input  logic signed [CORW-1:0]               max_z,
    output logic                                 neg
);

    localparam int PW = cfdc_pkg::COEF_W + CORW;
    localparam int SW = PW + 2;
    localparam logic signed [CORW-1:0] HEIGHT_S = CORW'(CHUNK_HEIGHT);

    logic signed [CORW-1:0] sel_x;
    logic signed [CORW-1:0] sel_z;
    logic signed [PW-1:0]   prod_a_next;
    logic signed [PW-1:0]   prod_b_next;
    logic signed [PW-1:0]   prod_c_next;
    logic signed [SW-1:0]   total;

    logic signed [PW-1:0]   prod_a_reg;
    logic signed [PW-1:0]   prod_b_reg;
    logic signed [PW-1:0]   prod_c_reg;
    logic signed [cfdc_pkg::COEF_W-1:0] d_reg;
    logic signed [SW-1:0]   sum_ab_reg;
    logic signed [SW-1:0]   sum_cd_reg;
    logic                   neg_reg;

    always_comb
    begin
        sel_x       = coef_a[cfdc_pkg::COEF_W-1] ? min_x : max_x;
        sel_z       = coef_c[cfdc_pkg::COEF_W-1] ? min_z : max_z;
        prod_a_next = coef_a * sel_x;
        prod_c_next = coef_c * sel_z;
        // y spans 0..CHUNK_HEIGHT; the minimum corner contributes nothing
        prod_b_next = coef_b[cfdc_pkg::COEF_W-1] ? '0 : coef_b * HEIGHT_S;
        total       = sum_ab_reg + sum_cd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            prod_c_reg <= prod_c_next;
            d_reg      <= coef_d;
        end
        if (adv.s4)
        begin
            sum_ab_reg <= SW'(prod_a_reg) + SW'(prod_b_reg);
            sum_cd_reg <= SW'(prod_c_reg) + SW'(d_reg);
        end
        if (adv.s5)
        begin
            neg_reg <= total[SW-1];
        end
    end

    assign neg = neg_reg;

endmodule

[rtl/core/chunk_frustum_distance_cull.sv]
`timescale 1ns / 1ps
// Chunk cull: render-distance check plus six-plane frustum test per chunk.
// Chunks pass through the stage registers to an output register; one chunk per cycle unless verdict.ready stalls.
// Ready is a combinational chain back from verdict.ready through six stages.
// Matrix loads take effect for every chunk transferred after them.
// Reset: matrix zero, camera chunk 0/0, render distance 8, pipeline empty.
module chunk_frustum_distance_cull #(
    parameter int CHUNK_SIZE   = cfdc_pkg::CHUNK_SIZE_DEF,
    parameter int CHUNK_HEIGHT = cfdc_pkg::CHUNK_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cfdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cfdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    cfdc_chunk_if.sink                          chunk,
    cfdc_verdict_if.source                      verdict
);

    localparam int CW   = cfdc_pkg::COEF_W;
    localparam int NP   = cfdc_pkg::NUM_PLANES;
    localparam int DW   = cfdc_pkg::COORD_W + 1;
    localparam int XW   = cfdc_pkg::COORD_W + $clog2(CHUNK_SIZE + 1) + 1;
    localparam int YW   = $clog2(CHUNK_HEIGHT + 1) + 1;
    localparam int CORW = (XW > YW) ? XW : YW;
    localparam logic signed [CORW-1:0] SIZE_S = CORW'(CHUNK_SIZE);

    // Configuration
    logic signed [cfdc_pkg::COORD_W-1:0] camera_x_reg;
    logic signed [cfdc_pkg::COORD_W-1:0] camera_z_reg;
    logic [cfdc_pkg::DIST_W-1:0]         render_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg    <= '0;
            camera_z_reg    <= '0;
            render_dist_reg <= cfdc_pkg::RENDER_DIST_RST;
        end
        else if (cfg_write)
        begin
            case (cfdc_pkg::cfg_reg_e'(cfg_index))
                cfdc_pkg::CFG_CAMERA_X:    camera_x_reg    <= cfg_data;
                cfdc_pkg::CFG_CAMERA_Z:    camera_z_reg    <= cfg_data;
                cfdc_pkg::CFG_RENDER_DIST: render_dist_reg <= cfg_data[cfdc_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic free_1, free_2, free_3, free_4, free_5, free_out;
    logic take, is_load, is_test;

    assign free_out = !out_valid_reg || verdict.ready;
    assign free_5   = !s5_valid_reg || free_out;
    assign free_4   = !s4_valid_reg || free_5;
    assign free_3   = !s3_valid_reg || free_4;
    assign free_2   = !s2_valid_reg || free_3;
    assign free_1   = !s1_valid_reg || free_2;

    assign chunk.ready = free_1;
    assign take        = chunk.valid && free_1;
    assign is_load     = (chunk.data.operation == cfdc_pkg::OP_LOAD);
    assign is_test     = (chunk.data.operation == cfdc_pkg::OP_TEST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free_1)
                s1_valid_reg <= take && is_test;
            if (free_2)
                s2_valid_reg <= s1_valid_reg;
            if (free_3)
                s3_valid_reg <= s2_valid_reg;
            if (free_4)
                s4_valid_reg <= s3_valid_reg;
            if (free_5)
                s5_valid_reg <= s4_valid_reg;
            if (free_out)
                out_valid_reg <= s5_valid_reg;
        end
    end

    // View-projection matrix, written on a load transfer
    logic signed [cfdc_pkg::ENTRY_W-1:0] matrix_reg [cfdc_pkg::MAT_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cfdc_pkg::MAT_DEPTH; i++)
                matrix_reg[i] <= '0;
        end
        else if (take && is_load)
        begin
            matrix_reg[chunk.data.entry_index] <= chunk.data.entry_value;
        end
    end

    // Stage 1: plane coefficients and axis offsets
    logic signed [CW-1:0] coef_next [NP][4];
    logic signed [DW-1:0] dx_next;
    logic signed [DW-1:0] dz_next;

    always_comb
    begin
        logic signed [CW-1:0] e0, e1, e2, e3;
        for (int k = 0; k < 4; k++)
        begin
            e0 = CW'(matrix_reg[4'(k * 4 + 0)]);
            e1 = CW'(matrix_reg[4'(k * 4 + 1)]);
            e2 = CW'(matrix_reg[4'(k * 4 + 2)]);
            e3 = CW'(matrix_reg[4'(k * 4 + 3)]);
            coef_next[0][k] = e3 + e0;
            coef_next[1][k] = e3 - e0;
            coef_next[2][k] = e3 + e1;
            coef_next[3][k] = e3 - e1;
            coef_next[4][k] = e2;
            coef_next[5][k] = e3 - e2;
        end
        dx_next = DW'(chunk.data.chunk_x) - DW'(camera_x_reg);
        dz_next = DW'(chunk.data.chunk_z) - DW'(camera_z_reg);
    end

    logic signed [CW-1:0]                s1_coef_reg [NP][4];
    logic signed [DW-1:0]                s1_dx_reg;
    logic signed [DW-1:0]                s1_dz_reg;
    logic signed [cfdc_pkg::COORD_W-1:0] s1_cx_reg;
    logic signed [cfdc_pkg::COORD_W-1:0] s1_cz_reg;
    logic                                s1_has_reg;

    always_ff @(posedge clk)
    begin
        if (free_1)
        begin
            s1_coef_reg <= coef_next;
            s1_dx_reg   <= dx_next;
            s1_dz_reg   <= dz_next;
            s1_cx_reg   <= chunk.data.chunk_x;
            s1_cz_reg   <= chunk.data.chunk_z;
            s1_has_reg  <= chunk.data.has_geometry;
        end
    end

    // Stage 2: distance flag and box corners
    logic [DW-1:0]          abs_dx, abs_dz;
    logic                   dist_next;
    logic signed [CORW-1:0] min_x_next, min_z_next;

    always_comb
    begin
        abs_dx     = s1_dx_reg[DW-1] ? DW'(-s1_dx_reg) : DW'(s1_dx_reg);
        abs_dz     = s1_dz_reg[DW-1] ? DW'(-s1_dz_reg) : DW'(s1_dz_reg);
        dist_next  = (abs_dx > DW'(render_dist_reg)) || (abs_dz > DW'(render_dist_reg));
        min_x_next = CORW'(s1_cx_reg) * SIZE_S;
        min_z_next = CORW'(s1_cz_reg) * SIZE_S;
    end

    logic signed [CW-1:0]   s2_coef_reg [NP][4];
    logic signed [CORW-1:0] s2_min_x_reg, s2_max_x_reg, s2_min_z_reg, s2_max_z_reg;
    logic                   s2_dist_reg, s2_has_reg;
    logic                   s3_dist_reg, s3_has_reg;
    logic                   s4_dist_reg, s4_has_reg;
    logic                   s5_dist_reg, s5_has_reg;

    always_ff @(posedge clk)
    begin
        if (free_2)
        begin
            s2_coef_reg  <= s1_coef_reg;
            s2_min_x_reg <= min_x_next;
            s2_max_x_reg <= min_x_next + SIZE_S;
            s2_min_z_reg <= min_z_next;
            s2_max_z_reg <= min_z_next + SIZE_S;
            s2_dist_reg  <= dist_next;
            s2_has_reg   <= s1_has_reg;
        end
        if (free_3)
        begin
            s3_dist_reg <= s2_dist_reg;
            s3_has_reg  <= s2_has_reg;
        end
        if (free_4)
        begin
            s4_dist_reg <= s3_dist_reg;
            s4_has_reg  <= s3_has_reg;
        end
        if (free_5)
        begin
            s5_dist_reg <= s4_dist_reg;
            s5_has_reg  <= s4_has_reg;
        end
    end

    // Stages 3-5: one lane per plane
    cfdc_pkg::adv_t  lane_adv;
    logic [NP-1:0]   plane_neg;

    assign lane_adv.s3 = free_3;
    assign lane_adv.s4 = free_4;
    assign lane_adv.s5 = free_5;

    for (genvar p = 0; p < NP; p++)
    begin : g_plane
        cfdc_plane_lane #(
            .CORW         (CORW),
            .CHUNK_HEIGHT (CHUNK_HEIGHT)
        ) u_lane (
            .clk    (clk),
            .adv    (lane_adv),
            .coef_a (s2_coef_reg[p][0]),
            .coef_b (s2_coef_reg[p][1]),
            .coef_c (s2_coef_reg[p][2]),
            .coef_d (s2_coef_reg[p][3]),
            .min_x  (s2_min_x_reg),
            .max_x  (s2_max_x_reg),
            .min_z  (s2_min_z_reg),
            .max_z  (s2_max_z_reg),
            .neg    (plane_neg[p])
        );
    end

    // Output register
    cfdc_pkg::verdict_t out_data_next;
    cfdc_pkg::verdict_t out_data_reg;

    always_comb
    begin
        out_data_next.distance_culled = s5_dist_reg;
        out_data_next.frustum_culled  = !s5_dist_reg && (|plane_neg);
        out_data_next.draw            = !s5_dist_reg && !(|plane_neg) && s5_has_reg;
    end

    always_ff @(posedge clk)
    begin
        if (free_out)
            out_data_reg <= out_data_next;
    end

    assign verdict.valid = out_valid_reg;
    assign verdict.data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (chunk.valid && chunk.ready && chunk.data.operation == cfdc_pkg::OP_LOAD)
        |=> !s1_valid_reg)
        else $error("matrix load entered the test pipeline");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && s5_valid_reg
         && out_valid_reg && !verdict.ready) |-> !chunk.ready)
        else $error("transfer accepted into a full stalled pipeline");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> !(verdict.data.draw &&
            (verdict.data.distance_culled || verdict.data.frustum_culled)) &&
            !(verdict.data.distance_culled && verdict.data.frustum_culled))
        else $error("inconsistent verdict flags");

    a_out_follows_s5: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && free_out) |=> verdict.valid)
        else $error("result lost between last stage and output register");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for chunk_frustum_distance_cull: directed and random chunk/matrix traffic,
// verdicts checked against an in-bench cull predictor. Depends on cfdc_pkg and cfdc_stream_if.

class cull_scoreboard;
    typedef enum int
    {
        PL_LEFT,
        PL_RIGHT,
        PL_BOTTOM,
        PL_TOP,
        PL_NEAR,
        PL_FAR
    } plane_e;

    logic signed [cfdc_pkg::ENTRY_W-1:0] matrix [cfdc_pkg::MAT_DEPTH];
    logic signed [cfdc_pkg::COORD_W-1:0] cam_x;
    logic signed [cfdc_pkg::COORD_W-1:0] cam_z;
    logic [cfdc_pkg::DIST_W-1:0]         reach;
    cfdc_pkg::verdict_t                  verdict_q [$];
    int                                  errors;

    function new();
        foreach (matrix[i])
        begin
            matrix[i] = '0;
        end
        cam_x  = '0;
        cam_z  = '0;
        reach  = cfdc_pkg::RENDER_DIST_RST;
        errors = 0;
    endfunction

    function void write_reg(cfdc_pkg::cfg_reg_e idx, logic [cfdc_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            cfdc_pkg::CFG_CAMERA_X:    cam_x = val;
            cfdc_pkg::CFG_CAMERA_Z:    cam_z = val;
            cfdc_pkg::CFG_RENDER_DIST: reach = val[cfdc_pkg::DIST_W-1:0];
            default: ;
        endcase
    endfunction

    // coefficient for axis k (x, y, z, w) of plane p
    function longint plane_coef(int p, int k);
        longint w;
        longint e0;
        longint e1;
        longint e2;
        w  = longint'(matrix[k*4+3]);
        e0 = longint'(matrix[k*4+0]);
        e1 = longint'(matrix[k*4+1]);
        e2 = longint'(matrix[k*4+2]);
        case (p)
            PL_LEFT:   return w + e0;
            PL_RIGHT:  return w - e0;
            PL_BOTTOM: return w + e1;
            PL_TOP:    return w - e1;
            PL_NEAR:   return e2;
            default:   return w - e2;
        endcase
    endfunction

    function cfdc_pkg::verdict_t cull_verdict(cfdc_pkg::chunk_item_t it);
        cfdc_pkg::verdict_t v;
        longint   dx;
        longint   dz;
        longint   lim;
        longint   lo [3];
        longint   hi [3];
        longint   c;
        longint   s;
        bit       far_off;
        bit       behind;
        dx  = longint'(it.chunk_x) - longint'(cam_x);
        dz  = longint'(it.chunk_z) - longint'(cam_z);
        lim = longint'(reach);
        if (dx < 0)
        begin
            dx = -dx;
        end
        if (dz < 0)
        begin
            dz = -dz;
        end
        far_off = (dx > lim) || (dz > lim);
        behind  = 1'b0;
        lo = '{longint'(it.chunk_x) * longint'(cfdc_pkg::CHUNK_SIZE_DEF), longint'(0),
               longint'(it.chunk_z) * longint'(cfdc_pkg::CHUNK_SIZE_DEF)};
        hi = '{lo[0] + longint'(cfdc_pkg::CHUNK_SIZE_DEF), longint'(cfdc_pkg::CHUNK_HEIGHT_DEF),
               lo[2] + longint'(cfdc_pkg::CHUNK_SIZE_DEF)};
        if (!far_off)
        begin
            for (int p = PL_LEFT; p <= PL_FAR; p++)
            begin
                s = plane_coef(p, 3);
                for (int k = 0; k < 3; k++)
                begin
                    c = plane_coef(p, k);
                    s += c * ((c >= 0) ? hi[k] : lo[k]);
                end
                if (s < 0)
                begin
                    behind = 1'b1;
                end
            end
        end
        v.draw            = !far_off && !behind && it.has_geometry;
        v.distance_culled = far_off;
        v.frustum_culled  = behind;
        return v;
    endfunction

    function void note_input(cfdc_pkg::chunk_item_t it);
        if (it.operation == cfdc_pkg::OP_LOAD)
        begin
            matrix[it.entry_index] = it.entry_value;
        end
        else
        begin
            verdict_q.push_back(cull_verdict(it));
        end
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction

    task report(string what, int got, int want);
        if (errors < 40)
        begin
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
        end
        errors++;
    endtask

    task check(cfdc_pkg::verdict_t got);
        cfdc_pkg::verdict_t want;
        if (verdict_q.size() == 0)
        begin
            report("unexpected verdict", int'(got), 0);
            return;
        end
        want = verdict_q.pop_front();
        if (got.draw !== want.draw)
        begin
            report("draw", int'(got.draw), int'(want.draw));
        end
        if (got.distance_culled !== want.distance_culled)
        begin
            report("distance_culled", int'(got.distance_culled), int'(want.distance_culled));
        end
        if (got.frustum_culled !== want.frustum_culled)
        begin
            report("frustum_culled", int'(got.frustum_culled), int'(want.frustum_culled));
        end
    endtask
endclass

module tb_top;
    localparam int LIMIT  = 200000;
    localparam int SETTLE = 10;
    localparam int HOLD   = 120;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [cfdc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cfdc_pkg::CFG_DATA_W-1:0]  cfg_data;
    bit                               calm;
    bit                               squeeze;
    int                               cycles;
    cull_scoreboard                   sb = new();

    cfdc_chunk_if   chunk_ch ();
    cfdc_verdict_if verdict_ch ();

    chunk_frustum_distance_cull u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chunk     (chunk_ch),
        .verdict   (verdict_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                sb.write_reg(cfdc_pkg::cfg_reg_e'(cfg_index), cfg_data);
            end
            if (chunk_ch.valid && chunk_ch.ready)
            begin
                sb.note_input(chunk_ch.data);
            end
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                sb.check(verdict_ch.data);
            end
        end
    end

    // verdict side: random stalls, plus one long hold-off on request
    initial
    begin
        verdict_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze)
            begin
                verdict_ch.ready <= 1'b0;
                repeat (HOLD) @(posedge clk);
                squeeze = 1'b0;
            end
            verdict_ch.ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    function automatic cfdc_pkg::chunk_item_t load_item(int idx,
                                                        logic [cfdc_pkg::ENTRY_W-1:0] val);
        cfdc_pkg::chunk_item_t it;
        it              = cfdc_pkg::chunk_item_t'({$urandom, $urandom, $urandom});
        it.operation    = cfdc_pkg::OP_LOAD;
        it.entry_index  = 4'(idx);
        it.entry_value  = val;
        return it;
    endfunction

    function automatic cfdc_pkg::chunk_item_t test_item(int x, int z, bit geo);
        cfdc_pkg::chunk_item_t it;
        it              = cfdc_pkg::chunk_item_t'({$urandom, $urandom, $urandom});
        it.operation    = cfdc_pkg::OP_TEST;
        it.chunk_x      = 16'(x);
        it.chunk_z      = 16'(z);
        it.has_geometry = geo;
        return it;
    endfunction

    // mostly chunks around the camera, some anywhere; a quarter are matrix loads
    function automatic cfdc_pkg::chunk_item_t random_item(int cx, int cz, int rd);
        cfdc_pkg::chunk_item_t it;
        int          span;
        it              = cfdc_pkg::chunk_item_t'({$urandom, $urandom, $urandom});
        it.has_geometry = ($urandom_range(99) < 80);
        span            = rd + 2;
        if ($urandom_range(3) == 0)
        begin
            it.operation = cfdc_pkg::OP_LOAD;
            if ($urandom_range(9) < 4)
            begin
                it.entry_value = int'($urandom_range(1 << 19)) - (1 << 18);
            end
        end
        else
        begin
            it.operation = cfdc_pkg::OP_TEST;
            if ($urandom_range(99) < 85)
            begin
                it.chunk_x = 16'(cx + int'($urandom_range(2 * span)) - span);
                it.chunk_z = 16'(cz + int'($urandom_range(2 * span)) - span);
            end
        end
        return it;
    endfunction

    task automatic send_item(cfdc_pkg::chunk_item_t it);
        while (!calm && $urandom_range(99) < 22)
        begin
            chunk_ch.valid <= 1'b0;
            @(posedge clk);
        end
        chunk_ch.valid <= 1'b1;
        chunk_ch.data  <= it;
        do
            @(posedge clk);
        while (!chunk_ch.ready);
    endtask

    task automatic drain();
        chunk_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_view(int cx, int cz, int rd);
        cfg_write <= 1'b1;
        cfg_index <= cfdc_pkg::CFG_CAMERA_X;
        cfg_data  <= cx[cfdc_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= cfdc_pkg::CFG_CAMERA_Z;
        cfg_data  <= cz[cfdc_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= cfdc_pkg::CFG_RENDER_DIST;
        cfg_data  <= {{(cfdc_pkg::CFG_DATA_W-cfdc_pkg::DIST_W){1'b0}},
                      rd[cfdc_pkg::DIST_W-1:0]};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(int cx, int cz, int rd, int count, bit quiet, bit choke);
        drain();
        write_view(cx, cz, rd);
        calm    = quiet;
        squeeze = choke;
        repeat (count) send_item(random_item(cx, cz, rd));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = cfdc_pkg::CFG_CAMERA_X;
        cfg_data       = '0;
        chunk_ch.valid = 1'b0;
        chunk_ch.data  = '0;
        calm           = 1'b0;
        squeeze        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: zero matrix, camera at origin, distance 8
        send_item(test_item(0, 0, 1'b1));
        send_item(test_item(8, -8, 1'b1));
        send_item(test_item(9, 0, 1'b1));
        send_item(test_item(0, -9, 1'b1));
        send_item(test_item(3, 2, 1'b0));
        send_item(test_item(32767, -32768, 1'b1));
        send_item(test_item(-32768, 32767, 1'b0));
        // near plane all-zero with negative w: everything in range is culled
        send_item(load_item(14, 32'hFFFF_FFFF));
        send_item(test_item(1, 1, 1'b1));
        send_item(test_item(20, 0, 1'b1));
        send_item(test_item(-2, 4, 1'b0));
        send_item(load_item(14, 32'h7FFF_FFFF));
        send_item(test_item(1, 1, 1'b1));
        send_item(load_item(0, 32'h0001_0000));
        send_item(load_item(5, 32'h0001_0000));
        send_item(load_item(10, 32'h8000_0000));
        send_item(load_item(15, 32'h7FFF_FFFF));
        send_item(test_item(0, 0, 1'b1));
        send_item(test_item(-8, 8, 1'b1));
        send_item(test_item(8, 8, 1'b0));
        send_item(test_item(-3, 5, 1'b1));
        send_item(load_item(15, 32'h8000_0000));
        send_item(test_item(2, -2, 1'b1));

        run_phase(5, -3, 0, 90, 1'b1, 1'b0);
        run_phase(32767, -32768, 255, 90, 1'b0, 1'b1);
        run_phase(-32768, 32767, 3, 90, 1'b0, 1'b0);
        run_phase(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                  $urandom_range(255), 90, 1'b0, 1'b0);
        run_phase(0, 0, 8, 90, 1'b0, 1'b0);
        drain();

        if (sb.errors == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/core/cfdc_pkg.sv
rtl/core/cfdc_stream_if.sv
rtl/core/cfdc_plane_lane.sv
rtl/core/chunk_frustum_distance_cull.sv
bench/tb_top.sv
